// ===== hw/rtl/sirq_pkg.sv =====
// Shared types and codes for the soft IRQ pending queue controller.
// No dependencies.
package sirq_pkg;

    // op codes carried on s_tuser
    localparam logic [2:0] OP_ENABLE   = 3'd0;
    localparam logic [2:0] OP_DISABLE  = 3'd1;
    localparam logic [2:0] OP_SET_PEND = 3'd2;
    localparam logic [2:0] OP_LOCK     = 3'd3;
    localparam logic [2:0] OP_UNLOCK   = 3'd4;
    localparam logic [2:0] OP_DISPATCH = 3'd5;

    // pending ring entry: a line number
    localparam int RING_DW = 5;

    // one result, packed as it appears on m_tdata (status in bit 0)
    typedef struct packed {
        logic [15:0]        overflow_total;
        logic [RING_DW-1:0] fired_irq;
        logic               fired;
        logic               was_unlocked;
        logic               status;
    } result_t;

endpackage

// ===== hw/rtl/sirq_ring.sv =====
// Pending ring storage: one write port, one registered read port.
// Depends on sirq_pkg.
module sirq_ring
    import sirq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [RING_DW-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [RING_DW-1:0] rd_data
);

    logic [RING_DW-1:0] mem [DEPTH];
    logic [RING_DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/soft_irq_pending_fifo_controller.sv =====
// Software interrupt controller: per-line enables, pending ring, nested lock.
// Depends on sirq_pkg and sirq_ring.
//
// One item at a time. An item is taken in the idle state and executed the
// next cycle; enable, disable, set pending, lock and unknown ops each give
// one result, and the block is ready again once that result is registered.
// A dispatch while unlocked, or the unlock that drops the depth to zero with
// mask set, drains the ring: a ring read state first, then one entry per
// cycle while the output slot is free, and the block takes the next item
// once the last entry is emitted; the pace is set by the ring's single read
// port. The output register lets a finished result wait for m_tready while
// the block goes on; back pressure only stalls the step that emits. The
// ring needs no clearing after reset.
module soft_irq_pending_fifo_controller
    import sirq_pkg::*;
#(
    parameter int NUM_LINES   = 32,
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // irq_index[7:0], prio[10:8], handler_present[11],
                                   // unlock_mask[12], zero[15:13]
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[0], was_unlocked[1], fired[2],
                                   // fired_irq[7:3], overflow_total[23:8]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [2:0]  cfg_wdata
);

    localparam int LINE_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int RA_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic       CFG_PRIO_MIN = 1'b0;
    localparam logic       CFG_PRIO_MAX = 1'b1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic [7:0]           idx_reg, idx_next;
    logic [2:0]           prio_reg, prio_next;
    logic                 hnd_reg, hnd_next;
    logic                 mask_reg, mask_next;
    logic [2:0]           prio_min_reg, prio_max_reg;
    logic [NUM_LINES-1:0] line_en_reg, line_en_next;
    logic [RA_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [15:0]          ovf_reg, ovf_next;
    logic [15:0]          lock_reg, lock_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_last_reg, out_last_next;
    result_t              out_data_reg, out_data_next;

    logic                 ring_we, ring_re;
    logic [RA_W-1:0]      ring_waddr, ring_raddr;
    logic [RING_DW-1:0]   ring_wdata, ring_rdata;

    logic                 slot_free, push, res_last;
    result_t              res;
    logic                 idx_ok, prio_ok, ring_full, line_sel, enable_bad;
    logic [LINE_W-1:0]    lidx;
    logic [CNT_W:0]       tail_sum;
    logic [RA_W-1:0]      tail, head_inc;
    logic [15:0]          ovf_inc;

    sirq_ring #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (RA_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (ring_waddr),
        .wr_data (ring_wdata),
        .rd_en   (ring_re),
        .rd_addr (ring_raddr),
        .rd_data (ring_rdata)
    );

    assign slot_free  = !out_valid_reg || m_tready;
    assign idx_ok     = {1'b0, idx_reg} < 9'(NUM_LINES);
    assign lidx       = idx_reg[LINE_W-1:0];
    assign line_sel   = line_en_reg[lidx];
    assign prio_ok    = (prio_reg >= prio_min_reg) && (prio_reg <= prio_max_reg);
    assign enable_bad = !idx_ok || !hnd_reg || !prio_ok;
    assign ring_full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign tail_sum   = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign tail       = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                        ? RA_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH))
                        : RA_W'(tail_sum);
    assign head_inc   = (head_reg == RA_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign ovf_inc    = (ovf_reg == 16'hFFFF) ? ovf_reg : ovf_reg + 16'd1;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        prio_next      = prio_reg;
        hnd_next       = hnd_reg;
        mask_next      = mask_reg;
        line_en_next   = line_en_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        lock_next      = lock_reg;
        ring_we        = 1'b0;
        ring_waddr     = tail;
        ring_wdata     = idx_reg[RING_DW-1:0];
        ring_re        = 1'b0;
        ring_raddr     = head_reg;
        push           = 1'b0;
        res_last       = 1'b1;
        res            = '0;
        res.overflow_total = ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    idx_next   = s_tdata[7:0];
                    prio_next  = s_tdata[10:8];
                    hnd_next   = s_tdata[11];
                    mask_next  = s_tdata[12];
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_ENABLE:
                    begin
                        res.status = enable_bad;
                        if (slot_free)
                        begin
                            push       = 1'b1;
                            state_next = ST_IDLE;
                            if (!enable_bad)
                            begin
                                line_en_next[lidx] = 1'b1;
                            end
                        end
                    end
                    OP_DISABLE:
                    begin
                        res.status = !idx_ok;
                        if (slot_free)
                        begin
                            push       = 1'b1;
                            state_next = ST_IDLE;
                            if (idx_ok)
                            begin
                                line_en_next[lidx] = 1'b0;
                            end
                        end
                    end
                    OP_SET_PEND:
                    begin
                        res.status = !idx_ok;
                        if (idx_ok && line_sel && ring_full)
                        begin
                            // full: overwrite the oldest slot and move head past it
                            res.overflow_total = ovf_inc;
                        end
                        if (slot_free)
                        begin
                            push       = 1'b1;
                            state_next = ST_IDLE;
                            if (idx_ok && line_sel)
                            begin
                                ring_we = 1'b1;
                                if (ring_full)
                                begin
                                    ring_waddr = head_reg;
                                    head_next  = head_inc;
                                    ovf_next   = ovf_inc;
                                end
                                else
                                begin
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                    end
                    OP_LOCK:
                    begin
                        res.was_unlocked = lock_reg == 16'd0;
                        if (slot_free)
                        begin
                            push       = 1'b1;
                            state_next = ST_IDLE;
                            if (lock_reg != 16'hFFFF)
                            begin
                                lock_next = lock_reg + 16'd1;
                            end
                        end
                    end
                    OP_UNLOCK:
                    begin
                        state_next = ST_IDLE;
                        if (lock_reg != 16'd0)
                        begin
                            lock_next = lock_reg - 16'd1;
                            if (lock_reg == 16'd1 && mask_reg && count_reg != '0)
                            begin
                                state_next = ST_READ;
                            end
                        end
                    end
                    OP_DISPATCH:
                    begin
                        state_next = ST_IDLE;
                        if (lock_reg == 16'd0 && count_reg != '0)
                        begin
                            state_next = ST_READ;
                        end
                    end
                    default:
                    begin
                        res.status = 1'b1;
                        if (slot_free)
                        begin
                            push       = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_READ:
            begin
                ring_re    = 1'b1;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                res.fired     = line_en_reg[ring_rdata[LINE_W-1:0]];
                res.fired_irq = ring_rdata;
                res_last      = count_reg == CNT_W'(1);
                if (slot_free)
                begin
                    push       = 1'b1;
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    if (res_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // fetch the next entry while this one goes out
                        ring_re    = 1'b1;
                        ring_raddr = head_inc;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_data_next  = out_data_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_last_next  = res_last;
            out_data_next  = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= '0;
            idx_reg       <= '0;
            prio_reg      <= '0;
            hnd_reg       <= 1'b0;
            mask_reg      <= 1'b0;
            prio_min_reg  <= 3'd0;
            prio_max_reg  <= 3'd3;
            line_en_reg   <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= '0;
            lock_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            prio_reg      <= prio_next;
            hnd_reg       <= hnd_next;
            mask_reg      <= mask_next;
            line_en_reg   <= line_en_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            lock_reg      <= lock_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            out_data_reg  <= out_data_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_PRIO_MIN: prio_min_reg <= cfg_wdata;
                    CFG_PRIO_MAX: prio_max_reg <= cfg_wdata;
                    default:      prio_min_reg <= prio_min_reg;
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/sirq_chk.sv =====
// Port-level checks for the soft IRQ pending queue controller, bound to the top.
// No dependencies beyond the top level's ports.
module sirq_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // a result that is not taken stays as it is
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // an error reply is a lone result with no lock or drain fields
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[7:1] == 7'd0 && m_tlast)
        else $error("error reply carries stray fields");

    // a fired drain entry is never a lock reply or an error
    a_fired_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> !m_tdata[0] && !m_tdata[1])
        else $error("fired result has status or lock bit");

    // one item at a time: ready drops right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule

bind soft_irq_pending_fifo_controller sirq_chk u_sirq_chk (.*);

// ===== verif/sirq_checker.sv =====
// Scoreboard for the soft IRQ pending queue controller: mirrors line enables,
// pending ring, overflow count and lock depth, and checks each result transfer.
// Depends on sirq_pkg; sirq_tb_pkg below is shared with tb_top.
package sirq_tb_pkg;

    // config register indexes
    localparam logic REG_PRIO_MIN = 1'b0;
    localparam logic REG_PRIO_MAX = 1'b1;

    // op codes with no meaning, rejected by the block
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

endpackage

module sirq_checker
    import sirq_pkg::*;
    import sirq_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [2:0]  cfg_wdata,
    output int          fail_count,
    output int          backlog,
    output int          checked
);

    localparam int LINES = 32;
    localparam int DEPTH = 64;

    typedef struct packed {
        result_t res;
        logic    last;
    } irq_reply_t;

    logic [LINES-1:0]   line_on;
    logic [RING_DW-1:0] pend_ring [DEPTH];
    int                 rd_ptr;
    int                 fill;
    logic [15:0]        drop_cnt;
    logic [15:0]        nest;
    logic [2:0]         lo_prio;
    logic [2:0]         hi_prio;
    irq_reply_t         expected_replies [$];
    int                 errs;
    int                 seen;

    task automatic push_reply(input logic st, input logic wu, input logic fi,
                              input logic [RING_DW-1:0] irq, input logic last);
        irq_reply_t r;
        r.res.status         = st;
        r.res.was_unlocked   = wu;
        r.res.fired          = fi;
        r.res.fired_irq      = irq;
        r.res.overflow_total = drop_cnt;
        r.last               = last;
        expected_replies.push_back(r);
    endtask

    // full ring: drop the oldest entry first
    task automatic queue_line(input logic [RING_DW-1:0] line);
        if (fill >= DEPTH) begin
            rd_ptr = (rd_ptr + 1) % DEPTH;
            fill--;
            if (drop_cnt != 16'hFFFF)
                drop_cnt++;
        end
        pend_ring[(rd_ptr + fill) % DEPTH] = line;
        fill++;
    endtask

    task automatic drain_ring();
        logic [RING_DW-1:0] line;
        while (fill > 0) begin
            line   = pend_ring[rd_ptr];
            rd_ptr = (rd_ptr + 1) % DEPTH;
            fill--;
            push_reply(1'b0, 1'b0, line_on[line], line, fill == 0);
        end
    endtask

    task automatic apply_command(input logic [2:0] op, input logic [7:0] idx,
                                 input logic [2:0] prio, input logic hnd,
                                 input logic msk);
        logic wu;
        case (op)
            OP_ENABLE: begin
                if (idx >= LINES || !hnd || prio < lo_prio || prio > hi_prio)
                    push_reply(1'b1, 1'b0, 1'b0, '0, 1'b1);
                else begin
                    line_on[idx[4:0]] = 1'b1;
                    push_reply(1'b0, 1'b0, 1'b0, '0, 1'b1);
                end
            end
            OP_DISABLE: begin
                if (idx >= LINES)
                    push_reply(1'b1, 1'b0, 1'b0, '0, 1'b1);
                else begin
                    line_on[idx[4:0]] = 1'b0;
                    push_reply(1'b0, 1'b0, 1'b0, '0, 1'b1);
                end
            end
            OP_SET_PEND: begin
                if (idx >= LINES)
                    push_reply(1'b1, 1'b0, 1'b0, '0, 1'b1);
                else begin
                    if (line_on[idx[4:0]])
                        queue_line(idx[4:0]);
                    push_reply(1'b0, 1'b0, 1'b0, '0, 1'b1);
                end
            end
            OP_LOCK: begin
                wu = (nest == 16'd0);
                if (nest != 16'hFFFF)
                    nest++;
                push_reply(1'b0, wu, 1'b0, '0, 1'b1);
            end
            OP_UNLOCK: begin
                // only the outermost unlock with mask set drains
                if (nest != 16'd0) begin
                    nest--;
                    if (nest == 16'd0 && msk)
                        drain_ring();
                end
            end
            OP_DISPATCH: begin
                if (nest == 16'd0)
                    drain_ring();
            end
            default: push_reply(1'b1, 1'b0, 1'b0, '0, 1'b1);
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        irq_reply_t want;
        result_t    got;
        logic       bad;
        if (!rst_n)
        begin
            line_on  = '0;
            rd_ptr   = 0;
            fill     = 0;
            drop_cnt = '0;
            nest     = '0;
            lo_prio  = 3'd0;
            hi_prio  = 3'd3;
            expected_replies.delete();
            errs = 0;
            seen = 0;
            fail_count <= 0;
            backlog    <= 0;
            checked    <= 0;
        end
        else
        begin
            // results first, so a stray result never matches this edge's command
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                seen++;
                if (expected_replies.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("[%0t] result with nothing pending: tdata %h tlast %b",
                                 $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    bad  = (got.status !== want.res.status)
                        || (got.was_unlocked !== want.res.was_unlocked)
                        || (got.fired !== want.res.fired)
                        || (got.fired_irq !== want.res.fired_irq)
                        || (got.overflow_total !== want.res.overflow_total)
                        || (m_tlast !== want.last);
                    if (bad)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display({"[%0t] result %0d (exp/got): status %b/%b ",
                                      "was_unlocked %b/%b fired %b/%b irq %0d/%0d ",
                                      "overflow %0d/%0d last %b/%b"},
                                     $time, seen,
                                     want.res.status, got.status,
                                     want.res.was_unlocked, got.was_unlocked,
                                     want.res.fired, got.fired,
                                     want.res.fired_irq, got.fired_irq,
                                     want.res.overflow_total, got.overflow_total,
                                     want.last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_command(s_tuser, s_tdata[7:0], s_tdata[10:8], s_tdata[11],
                              s_tdata[12]);
            if (cfg_we)
            begin
                if (cfg_addr == REG_PRIO_MIN)
                    lo_prio = cfg_wdata;
                else
                    hi_prio = cfg_wdata;
            end
            fail_count <= errs;
            backlog    <= expected_replies.size();
            checked    <= seen;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Top of the soft IRQ pending queue controller testbench: clock, reset,
// command and result stream drivers, priority window writes, verdict.
// Depends on sirq_pkg, sirq_tb_pkg and sirq_checker.
module tb_top;
    import sirq_pkg::*;
    import sirq_tb_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // irq_index[7:0], prio[10:8], handler_present[11],
                                   // unlock_mask[12], zero[15:13]
    logic [2:0]  s_tuser   = '0;   // op[2:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // status[0], was_unlocked[1], fired[2],
                                   // fired_irq[7:3], overflow_total[23:8]
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [2:0]  cfg_wdata = '0;

    int          fail_count;
    int          backlog;
    int          checked;

    int          sent       = 0;
    int          windows    = 0;
    int          nest_guess = 0;
    logic [2:0]  cur_lo     = 3'd0;
    logic [2:0]  cur_hi     = 3'd3;
    bit          send_calm  = 1'b0;
    bit          recv_calm  = 1'b0;

    soft_irq_pending_fifo_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    sirq_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .backlog    (backlog),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int idle_draw(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    // one command transfer; valid stays up when the next one follows at once
    task automatic issue(input logic [2:0] op, input logic [7:0] idx,
                         input logic [2:0] prio, input logic hnd, input logic msk);
        int gap;
        gap = idle_draw(send_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, msk, hnd, prio, idx};
        do @(posedge clk); while (!s_tready);
        sent++;
        if (op == OP_LOCK && nest_guess < 65535)
            nest_guess++;
        else if (op == OP_UNLOCK && nest_guess > 0)
            nest_guess--;
        if ($urandom_range(0, 29) == 0)
            send_calm = ~send_calm;
    endtask

    // wait until every expected result is in and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (backlog != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_window(input logic [2:0] lo, input logic [2:0] hi);
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_PRIO_MIN;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_addr  <= REG_PRIO_MAX;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
        windows++;
    endtask

    task automatic rand_command();
        int         pick;
        logic [2:0] op;
        logic [7:0] idx;
        logic [2:0] prio;
        logic       hnd;
        logic       msk;
        pick = $urandom_range(0, 99);
        idx  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(32, 255))
                                           : 8'($urandom_range(0, 31));
        prio = 3'($urandom_range(0, 7));
        hnd  = ($urandom_range(0, 9) != 0);
        msk  = 1'($urandom_range(0, 1));
        if (pick < 18)
        begin
            op = OP_ENABLE;
            if (cur_lo <= cur_hi && $urandom_range(0, 4) != 0)
                prio = 3'($urandom_range(cur_lo, cur_hi));
        end
        else if (pick < 26)
            op = OP_DISABLE;
        else if (pick < 58)
            op = OP_SET_PEND;
        else if (pick < 68)
            op = (nest_guess >= 4) ? OP_UNLOCK : OP_LOCK;
        else if (pick < 80)
            op = OP_UNLOCK;
        else if (pick < 96)
            op = OP_DISPATCH;
        else
            op = ($urandom_range(0, 1) == 0) ? OP_RSVD_6 : OP_RSVD_7;
        issue(op, idx, prio, hnd, msk);
    endtask

    // result side: random stalls, with calm stretches
    initial
    begin
        int gap;
        forever
        begin
            gap = idle_draw(recv_calm);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if ($urandom_range(0, 29) == 0)
                recv_calm = ~recv_calm;
        end
    end

    // watchdog: cycles with no transfer on either stream
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("soft_irq_pending_fifo_controller: mismatch");
        $finish;
    end

    initial
    begin
        int k;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset window 0..3
        issue(OP_DISPATCH, 8'd0,   3'd0, 1'b0, 1'b0);   // empty ring
        issue(OP_UNLOCK,   8'd0,   3'd0, 1'b0, 1'b1);   // not locked, ignored
        issue(OP_ENABLE,   8'd0,   3'd0, 1'b1, 1'b0);
        issue(OP_ENABLE,   8'd31,  3'd3, 1'b1, 1'b0);
        issue(OP_ENABLE,   8'd32,  3'd0, 1'b1, 1'b0);   // line out of range
        issue(OP_ENABLE,   8'd255, 3'd7, 1'b1, 1'b1);
        issue(OP_ENABLE,   8'd5,   3'd1, 1'b0, 1'b0);   // no handler
        issue(OP_ENABLE,   8'd6,   3'd4, 1'b1, 1'b0);   // prio above window
        issue(OP_SET_PEND, 8'd0,   3'd0, 1'b0, 1'b0);
        issue(OP_SET_PEND, 8'd31,  3'd0, 1'b0, 1'b0);
        issue(OP_SET_PEND, 8'd5,   3'd0, 1'b0, 1'b0);   // disabled line, not queued
        issue(OP_SET_PEND, 8'd255, 3'd0, 1'b0, 1'b0);
        issue(OP_DISABLE,  8'd31,  3'd0, 1'b0, 1'b0);   // queued entry now won't fire
        issue(OP_DISABLE,  8'd32,  3'd0, 1'b0, 1'b0);
        issue(OP_RSVD_6,   8'd3,   3'd2, 1'b1, 1'b1);
        issue(OP_RSVD_7,   8'd0,   3'd0, 1'b0, 1'b0);
        issue(OP_LOCK,     8'd0,   3'd0, 1'b0, 1'b0);
        issue(OP_LOCK,     8'd0,   3'd0, 1'b0, 1'b0);   // nested
        issue(OP_DISPATCH, 8'd0,   3'd0, 1'b0, 1'b0);   // locked, no drain
        issue(OP_UNLOCK,   8'd0,   3'd0, 1'b0, 1'b1);   // still nested
        issue(OP_UNLOCK,   8'd0,   3'd0, 1'b0, 1'b1);   // outermost, drains two
        issue(OP_LOCK,     8'd0,   3'd0, 1'b0, 1'b0);
        issue(OP_SET_PEND, 8'd0,   3'd0, 1'b0, 1'b0);
        issue(OP_UNLOCK,   8'd0,   3'd0, 1'b0, 1'b0);   // mask clear, no drain
        issue(OP_DISPATCH, 8'd0,   3'd0, 1'b0, 1'b0);

        // fill past the ring depth, then one full drain
        for (k = 0; k < 4; k++)
            issue(OP_ENABLE, 8'(k), 3'd1, 1'b1, 1'b0);
        for (k = 0; k < 70; k++)
            issue(OP_SET_PEND, 8'(k % 4), 3'd0, 1'b0, 1'b0);
        issue(OP_DISPATCH, 8'd0, 3'd0, 1'b0, 1'b0);

        // random traffic across priority windows, empty and inverted ones too
        set_window(3'd0, 3'd7);
        repeat (40) rand_command();
        set_window(3'd7, 3'd7);
        repeat (40) rand_command();
        set_window(3'd5, 3'd2);
        repeat (40) rand_command();
        set_window(3'd0, 3'd0);
        repeat (40) rand_command();
        set_window(3'd2, 3'd5);
        repeat (40) rand_command();

        // unwind any open locks, then a last dispatch
        while (nest_guess > 0)
            issue(OP_UNLOCK, 8'd0, 3'd0, 1'b0, 1'b1);
        issue(OP_DISPATCH, 8'd0, 3'd0, 1'b0, 1'b0);
        settle();

        $display("run covered %0d commands over %0d priority windows, %0d results checked",
                 sent, windows, checked);
        $display("incl. full-ring drops, nested locks and masked and unmasked unlocks");
        if (fail_count == 0)
            $display("soft_irq_pending_fifo_controller: match");
        else
            $display("soft_irq_pending_fifo_controller: mismatch");
        $finish;
    end

endmodule
